@@ hw/rtl/itoa_pkg.sv @@
// ----------------------------------------------------------------------------
// itoa_pkg
// Shared widths, character codes and controller/datapath interface types
// for the signed integer to decimal text converter.
// ----------------------------------------------------------------------------
package itoa_pkg;

    localparam int ValW   = 32;              // input integer width
    localparam int CharW  = 8;               // ASCII character width
    localparam int DigW   = 4;               // one decimal digit
    localparam int NumDig = 10;              // digits of a 32-bit magnitude
    localparam int IdxW   = $clog2(NumDig);  // digit buffer index

    localparam logic [CharW-1:0] CH_ZERO  = 8'd48;
    localparam logic [CharW-1:0] CH_MINUS = 8'd45;
    localparam int               RADIX    = 10;

    // floor(n / 10) == (n * 0xCCCCCCCD) >> 35 for every 32-bit n
    localparam logic [ValW-1:0] RECIP       = 32'hCCCC_CCCD;
    localparam int              RECIP_SHIFT = 35;

    // controller -> datapath
    typedef struct packed {
        logic load;      // capture sign and magnitude of a new item
        logic mul_en;    // register magnitude times reciprocal
        logic div_step;  // store one digit, magnitude <= quotient
        logic out_load;  // load the output character register
        logic out_sign;  // with out_load: emit '-' instead of a digit
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic neg;        // item was negative
        logic quot_zero;  // quotient of the current step is zero
        logic ptr_zero;   // next digit to emit is the least significant
    } sts_t;

endpackage

@@ hw/rtl/itoa_dp.sv @@
// ----------------------------------------------------------------------------
// itoa_dp
// Datapath: magnitude register, reciprocal multiplier, digit buffer and
// output character register.
// ----------------------------------------------------------------------------
module itoa_dp (
    input  logic                          aclk,
    input  itoa_pkg::cmd_t                cmd,
    input  logic [itoa_pkg::ValW-1:0]     value,
    output itoa_pkg::sts_t                sts,
    output logic [itoa_pkg::CharW-1:0]    char_code,
    output logic                          last
);
    import itoa_pkg::*;

    logic [ValW-1:0]   mag_reg;
    logic              neg_reg;
    logic [2*ValW-1:0] prod_reg;
    logic [DigW-1:0]   digit_mem [NumDig];
    logic [IdxW-1:0]   nd_reg;
    logic [IdxW-1:0]   ptr_reg;
    logic [CharW-1:0]  char_reg;
    logic              last_reg;

    logic [ValW-1:0] abs_val;
    logic [ValW-1:0] quot;
    logic [ValW-1:0] quot_x10;
    logic [ValW-1:0] rem;

    // two's complement negate wraps the most negative value onto 2^31
    assign abs_val  = value[ValW-1] ? (~value + ValW'(1)) : value;
    assign quot     = ValW'(prod_reg >> RECIP_SHIFT);
    assign quot_x10 = ValW'(quot * ValW'(RADIX));
    assign rem      = mag_reg - quot_x10;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            mag_reg <= abs_val;
            neg_reg <= value[ValW-1];
            nd_reg  <= '0;
        end
        if (cmd.mul_en) begin
            prod_reg <= mag_reg * RECIP;
        end
        if (cmd.div_step) begin
            digit_mem[nd_reg] <= rem[DigW-1:0];
            ptr_reg           <= nd_reg;
            nd_reg            <= nd_reg + IdxW'(1);
            mag_reg           <= quot;
        end
        if (cmd.out_load) begin
            if (cmd.out_sign) begin
                char_reg <= CH_MINUS;
                last_reg <= 1'b0;
            end else begin
                char_reg <= CH_ZERO + CharW'(digit_mem[ptr_reg]);
                last_reg <= (ptr_reg == '0);
                if (ptr_reg != '0) begin
                    ptr_reg <= ptr_reg - IdxW'(1);
                end
            end
        end
    end

    assign sts.neg       = neg_reg;
    assign sts.quot_zero = (quot == '0);
    assign sts.ptr_zero  = (ptr_reg == '0);
    assign char_code     = char_reg;
    assign last          = last_reg;

endmodule

@@ hw/rtl/itoa_ctrl.sv @@
// ----------------------------------------------------------------------------
// itoa_ctrl
// Controller: sequences digit extraction and character emission, and owns
// the input ready and output valid handshakes.
// ----------------------------------------------------------------------------
module itoa_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    output logic           s_tready,
    output logic           m_tvalid,
    input  logic           m_tready,
    input  itoa_pkg::sts_t sts,
    output itoa_pkg::cmd_t cmd
);
    import itoa_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_SIGN,
        ST_DIGITS
    } state_t;

    state_t state_reg, state_next;
    logic   m_tvalid_reg, m_tvalid_next;
    logic   out_free;

    assign out_free = !m_tvalid_reg || m_tready;

    always_comb begin
        cmd           = '0;
        state_next    = state_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                cmd.mul_en = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (sts.quot_zero) begin
                    state_next = sts.neg ? ST_SIGN : ST_DIGITS;
                end else begin
                    state_next = ST_MUL;
                end
            end
            ST_SIGN: begin
                if (out_free) begin
                    cmd.out_load  = 1'b1;
                    cmd.out_sign  = 1'b1;
                    m_tvalid_next = 1'b1;
                    state_next    = ST_DIGITS;
                end
            end
            ST_DIGITS: begin
                if (out_free) begin
                    cmd.out_load  = 1'b1;
                    m_tvalid_next = 1'b1;
                    if (sts.ptr_zero) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;

endmodule

@@ hw/rtl/signed_int_to_decimal_ascii_core.sv @@
// Sequence: each decimal digit is extracted in an ST_MUL then an ST_DIV step,
//   then one character per cycle while m_tready does not stall, minus sign
//   first when negative. Digits per item: nd = 1..10.
// Throughput: one item at a time; the next item is accepted only after the
//   last character loads, so the digit loop and character output set the pace.
// Reset: synchronous active-low aresetn clears the controller and m_tvalid;
//   datapath registers are not reset.
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii_core
// Converts a 32-bit two's complement integer into its decimal ASCII text,
// most significant character first, with tlast on the final character.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii_core (
    input  logic                        aclk,
    input  logic                        aresetn,
    // input item
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [itoa_pkg::ValW-1:0]   s_tdata,   // [31:0] value (signed)
    // result items
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [itoa_pkg::CharW-1:0]  m_tdata,   // [7:0] char_code
    output logic                        m_tlast    // last character of run
);
    import itoa_pkg::*;

    cmd_t cmd;
    sts_t sts;

    // Controller: one item at a time. Digits come out least significant
    // first from the divide loop, are buffered, then replayed in reverse.
    itoa_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Datapath: divide by ten via reciprocal multiply (registered product),
    // remainder by shift-add and subtract on the next cycle. The output
    // character register lets the next character load as the current one
    // is taken.
    itoa_dp u_dp (
        .aclk      (aclk),
        .cmd       (cmd),
        .value     (s_tdata),
        .sts       (sts),
        .char_code (m_tdata),
        .last      (m_tlast)
    );

endmodule

@@ hw/rtl/itoa_checker.sv @@
// ----------------------------------------------------------------------------
// itoa_checker
// Port-level checks for the converter, bound to the top level.
// ----------------------------------------------------------------------------
module itoa_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [7:0]  m_tdata,
    input logic        m_tlast
);
    import itoa_pkg::*;

    // held result stays put while stalled
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result changed while stalled");

    // only minus or decimal digits leave the block
    a_char_set: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata == CH_MINUS) ||
                     ((m_tdata >= CH_ZERO) && (m_tdata <= CH_ZERO + 8'd9)))
        else $error("illegal character code");

    // a minus sign never ends a run
    a_sign_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata == CH_MINUS) |-> !m_tlast)
        else $error("minus sign flagged last");

    // one item in flight: ready drops right after an accept
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second item accepted while converting");

    // reset leaves no result pending
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind signed_int_to_decimal_ascii_core itoa_checker u_itoa_checker (.*);
